// ----- rtl/thac_pkg.sv -----
// Package for the thermistor linearizer: datapath widths, fixed constants,
// band limits and the Steinhart-Hart coefficient table.
// Depends on nothing; used by the top level, the testbench and its checker.
package thac_pkg;

    localparam int T_W      = 48;
    localparam int ACC_W    = 64;
    localparam int MB_W     = 28;
    localparam int M_W      = 31;
    localparam int SQ_W     = 62;
    localparam int LOG_FRAC = 30;
    localparam int MUL_STEPS = 28;
    localparam int L_W      = 26;

    localparam logic [MB_W-1:0] LN2_Q28      = 28'd186065279;
    localparam logic [63:0]     KELVIN_SCALE = 64'd1000000000000000;

    localparam logic [63:0] BAND0_HI = 64'd692600 << 16;
    localparam logic [63:0] BAND0_LO = 64'd32770 << 16;
    localparam logic [63:0] BAND1_LO = 64'd3599 << 16;
    localparam logic [63:0] BAND2_LO = 64'd44669338;
    localparam logic [63:0] BAND3_LO = 64'd187 << 16;

    localparam int TEMP_MAX = 65535;
    localparam int TEMP_MIN = -65536;

    localparam logic REG_SERIES  = 1'b0;
    localparam logic REG_NOMINAL = 1'b1;

    typedef logic signed [T_W-1:0] coef_t;

    function automatic coef_t coef(input logic [1:0] set, input logic [1:0] k);
        coef_t c;
        c = '0;
        case (set)
            2'd0: begin
                case (k)
                    2'd0: c = 48'sd3357042000000;
                    2'd1: c = 48'sd252148480000;
                    2'd2: c = 48'sd3374328300;
                    default: c = -48'sd64957311;
                endcase
            end
            2'd1: begin
                case (k)
                    2'd0: c = 48'sd3354017000000;
                    2'd1: c = 48'sd256172440000;
                    2'd2: c = 48'sd2140094300;
                    default: c = -48'sd72405219;
                endcase
            end
            2'd2: begin
                case (k)
                    2'd0: c = 48'sd3353048100000;
                    2'd1: c = 48'sd254202300000;
                    2'd2: c = 48'sd1143116300;
                    default: c = -48'sd69383563;
                endcase
            end
            default: begin
                case (k)
                    2'd0: c = 48'sd3353616600000;
                    2'd1: c = 48'sd253772000000;
                    2'd2: c = 48'sd854332710;
                    default: c = -48'sd87912262;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/thermistor_adc_to_celsius.sv -----
// Thermistor ADC sample to Celsius converter, top level.
// Depends on thac_pkg for widths, constants and the coefficient table.
//
// A request on the input channel (in_valid/in_ready) carries one ADC sample.
// Each request gives exactly one result on the output channel (out_valid/
// out_ready): the held temperature in signed Q8.8 Celsius and an
// out_of_range flag. An out-of-range request leaves the held value unchanged.
// The block works on one request at a time. An out-of-range request gives its
// result after the resistance division; any other goes on through the
// normalization of both logarithm inputs, the squaring steps of each
// logarithm, four shift-add products, the Kelvin division and saturation.
// in_ready is high only while no request is in work, so a new request is
// taken at the earliest in the cycle after the previous result is loaded.
// A finished result waits in the output register; the next request may be
// taken meanwhile, but its result waits until out_ready frees the register.
// Reset restores both registers to 10000 ohms, the held temperature to
// 100 Celsius and empties the output register. Registers are written
// over an APB port at byte addresses 0 and 4; the user must see that they
// are written only while the block is idle, which the block does not enforce.
module thermistor_adc_to_celsius #(
    parameter int ADC_BITS      = 12,
    parameter int FRACTION_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [11:0]        adc_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [16:0] temperature_q8_8,
    output logic               out_of_range,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int R_W   = 36 + ADC_BITS;
    localparam int DIV_W = 50 + FRACTION_BITS;
    localparam int P_W   = $clog2(R_W);
    localparam int LOG_W = P_W + thac_pkg::LOG_FRAC;
    localparam int D_W   = LOG_W + 2;
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam int OFF   = ((27315 << FRACTION_BITS) + 50) / 100;
    localparam int RST_T = ((100 << FRACTION_BITS) > thac_pkg::TEMP_MAX) ?
                           thac_pkg::TEMP_MAX : (100 << FRACTION_BITS);

    localparam logic [ADC_BITS-1:0] FULL      = {ADC_BITS{1'b1}};
    localparam logic [DIV_W-1:0]    KNUM      = DIV_W'(thac_pkg::KELVIN_SCALE) << FRACTION_BITS;
    localparam logic [DIV_W:0]      OFF_X     = (DIV_W + 1)'(OFF);
    localparam logic signed [DIV_W:0] LIM_HI  = (DIV_W + 1)'(thac_pkg::TEMP_MAX);
    localparam logic signed [DIV_W:0] LIM_LO  = -((DIV_W + 1)'(65536));
    localparam logic [D_W-1:0]      SIXTEEN   = D_W'(16) << thac_pkg::LOG_FRAC;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_DIV  = 11'b00000000010,
        ST_BAND = 11'b00000000100,
        ST_NORM = 11'b00000001000,
        ST_SQR  = 11'b00000010000,
        ST_DEC  = 11'b00000100000,
        ST_MUL  = 11'b00001000000,
        ST_MEND = 11'b00010000000,
        ST_PLD  = 11'b00100000000,
        ST_SAT  = 11'b01000000000,
        ST_DONE = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [19:0] series_reg, nominal_reg;
    logic signed [16:0] held_reg, held_next;
    logic oor_reg, oor_next;
    logic out_valid_reg, out_valid_next;
    logic signed [16:0] temp_out_reg, temp_out_next;
    logic oor_out_reg, oor_out_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic div_kel_reg, div_kel_next;
    logic log_two_reg, log_two_next;
    logic mul_ln_reg, mul_ln_next;
    logic fin_reg, fin_next;
    logic [1:0] set_reg, set_next;
    logic [1:0] k_reg, k_next;
    logic neg_reg, neg_next;
    logic lsign_reg, lsign_next;
    logic [thac_pkg::L_W-1:0] lmag_reg, lmag_next;

    logic [DIV_W-1:0] div_num_reg, div_num_next;
    logic [thac_pkg::T_W-1:0] div_rem_reg, div_rem_next;
    logic [thac_pkg::T_W-1:0] div_den_reg, div_den_next;
    logic [R_W-1:0] lv_reg, lv_next;
    logic [P_W-1:0] p_reg, p_next;
    logic [thac_pkg::M_W-1:0] m_reg, m_next;
    logic [thac_pkg::SQ_W-1:0] sq_reg, sq_next;
    logic [thac_pkg::LOG_FRAC-1:0] frac_reg, frac_next;
    logic [LOG_W-1:0] lr_reg, lr_next;
    logic [thac_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [thac_pkg::ACC_W-1:0] mul_a_reg, mul_a_next;
    logic [thac_pkg::MB_W-1:0] mul_b_reg, mul_b_next;
    logic signed [thac_pkg::T_W-1:0] t_reg, t_next;

    logic [ADC_BITS+11:0] raw_ext;
    logic [ADC_BITS-1:0] raw;
    logic [19+ADC_BITS:0] prod;
    logic [thac_pkg::T_W:0] div_shift, div_diff;
    logic div_ge;
    logic [31:0] sq_hi;
    logic [thac_pkg::LOG_FRAC-1:0] frac_shift;
    logic [LOG_W-1:0] logv;
    logic [D_W-1:0] dval, dmag;
    logic [R_W-1:0] r_val;
    logic [63:0] r_x;
    logic [19:0] r25;
    logic [thac_pkg::T_W-1:0] pm, psig, t_abs;
    logic signed [thac_pkg::T_W-1:0] t_new;
    logic signed [DIV_W:0] kdiff;
    logic [thac_pkg::L_W-1:0] lmag_new;

    assign in_ready         = (state_reg == ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign temperature_q8_8 = temp_out_reg;
    assign out_of_range     = oor_out_reg;
    assign pready           = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            thac_pkg::REG_SERIES:  prdata = {12'b0, series_reg};
            thac_pkg::REG_NOMINAL: prdata = {12'b0, nominal_reg};
        endcase
    end

    always_comb
    begin
        raw_ext    = {{ADC_BITS{1'b0}}, adc_sample};
        raw        = (raw_ext[ADC_BITS-1:0] == FULL) ? FULL - 1'b1 : raw_ext[ADC_BITS-1:0];
        prod       = series_reg * raw;
        div_shift  = {div_rem_reg, div_num_reg[DIV_W-1]};
        div_ge     = div_shift >= {1'b0, div_den_reg};
        div_diff   = div_shift - {1'b0, div_den_reg};
        sq_hi      = sq_reg[thac_pkg::SQ_W-1:thac_pkg::LOG_FRAC];
        frac_shift = {frac_reg[thac_pkg::LOG_FRAC-2:0], sq_hi[31]};
        logv       = {p_reg, frac_shift};
        dval       = D_W'(lr_reg) - SIXTEEN - D_W'(logv);
        dmag       = dval[D_W-1] ? -dval : dval;
        r_val      = div_num_reg[R_W-1:0];
        r_x        = 64'(r_val);
        r25        = (nominal_reg == 20'd0) ? 20'd1 : nominal_reg;
        pm         = thac_pkg::T_W'(acc_reg[thac_pkg::ACC_W-1:20]);
        psig       = neg_reg ? -pm : pm;
        t_new      = $signed(psig) + thac_pkg::coef(set_reg, k_reg);
        t_abs      = t_reg[thac_pkg::T_W-1] ? -t_reg : t_reg;
        kdiff      = $signed({1'b0, div_num_reg} - OFF_X);
        lmag_new   = acc_reg[thac_pkg::ACC_W-1:38];
    end

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg;
        temp_out_next  = temp_out_reg;
        oor_out_next   = oor_out_reg;
        cnt_next       = cnt_reg;
        div_kel_next   = div_kel_reg;
        log_two_next   = log_two_reg;
        mul_ln_next    = mul_ln_reg;
        fin_next       = fin_reg;
        set_next       = set_reg;
        k_next         = k_reg;
        neg_next       = neg_reg;
        lsign_next     = lsign_reg;
        lmag_next      = lmag_reg;
        div_num_next   = div_num_reg;
        div_rem_next   = div_rem_reg;
        div_den_next   = div_den_reg;
        lv_next        = lv_reg;
        p_next         = p_reg;
        m_next         = m_reg;
        sq_next        = sq_reg;
        frac_next      = frac_reg;
        lr_next        = lr_reg;
        acc_next       = acc_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        t_next         = t_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    div_num_next = DIV_W'({prod, 16'b0}) << (DIV_W - R_W);
                    div_rem_next = '0;
                    div_den_next = thac_pkg::T_W'(FULL - raw);
                    div_kel_next = 1'b0;
                    cnt_next     = CNT_W'(R_W);
                    oor_next     = 1'b0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                div_rem_next = div_ge ? div_diff[thac_pkg::T_W-1:0]
                                      : div_shift[thac_pkg::T_W-1:0];
                div_num_next = {div_num_reg[DIV_W-2:0], div_ge};
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = div_kel_reg ? ST_SAT : ST_BAND;
                end
            end
            ST_BAND:
            begin
                lv_next      = r_val;
                p_next       = P_W'(R_W - 1);
                log_two_next = 1'b0;
                state_next   = ST_NORM;
                if (r_x < thac_pkg::BAND0_HI && r_x >= thac_pkg::BAND0_LO)
                begin
                    set_next = 2'd0;
                end
                else if (r_x < thac_pkg::BAND0_LO && r_x >= thac_pkg::BAND1_LO)
                begin
                    set_next = 2'd1;
                end
                else if (r_x < thac_pkg::BAND1_LO && r_x >= thac_pkg::BAND2_LO)
                begin
                    set_next = 2'd2;
                end
                else if (r_x < thac_pkg::BAND2_LO && r_x >= thac_pkg::BAND3_LO)
                begin
                    set_next = 2'd3;
                end
                else
                begin
                    oor_next   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_NORM:
            begin
                if (lv_reg[R_W-1])
                begin
                    m_next     = lv_reg[R_W-1 -: thac_pkg::M_W];
                    frac_next  = '0;
                    cnt_next   = CNT_W'(thac_pkg::LOG_FRAC);
                    state_next = ST_SQR;
                end
                else
                begin
                    lv_next = {lv_reg[R_W-2:0], 1'b0};
                    p_next  = p_reg - 1'b1;
                end
            end
            ST_SQR:
            begin
                sq_next    = m_reg * m_reg;
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                m_next    = sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
                frac_next = frac_shift;
                cnt_next  = cnt_reg - 1'b1;
                state_next = ST_SQR;
                if (cnt_reg == CNT_W'(1))
                begin
                    if (!log_two_reg)
                    begin
                        lr_next      = logv;
                        lv_next      = R_W'(r25);
                        p_next       = P_W'(R_W - 1);
                        log_two_next = 1'b1;
                        state_next   = ST_NORM;
                    end
                    else
                    begin
                        lsign_next  = dval[D_W-1];
                        mul_a_next  = thac_pkg::ACC_W'(dmag);
                        mul_b_next  = thac_pkg::LN2_Q28;
                        acc_next    = thac_pkg::ACC_W'(1) << 37;
                        mul_ln_next = 1'b1;
                        cnt_next    = CNT_W'(thac_pkg::MUL_STEPS);
                        state_next  = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                acc_next   = acc_reg + (mul_b_reg[0] ? mul_a_reg : '0);
                mul_a_next = {mul_a_reg[thac_pkg::ACC_W-2:0], 1'b0};
                mul_b_next = {1'b0, mul_b_reg[thac_pkg::MB_W-1:1]};
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_MEND;
                end
            end
            ST_MEND:
            begin
                state_next = ST_PLD;
                if (mul_ln_reg)
                begin
                    lmag_next   = lmag_new;
                    lsign_next  = lsign_reg && (lmag_new != '0);
                    t_next      = thac_pkg::coef(set_reg, 2'd3);
                    k_next      = 2'd2;
                    fin_next    = 1'b0;
                    mul_ln_next = 1'b0;
                end
                else
                begin
                    t_next = t_new;
                    if (k_reg == 2'd0)
                    begin
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        k_next = k_reg - 1'b1;
                    end
                end
            end
            ST_PLD:
            begin
                if (fin_reg)
                begin
                    if (t_reg <= 0)
                    begin
                        held_next  = 17'(thac_pkg::TEMP_MAX);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_num_next = KNUM + DIV_W'(t_reg[thac_pkg::T_W-1:1]);
                        div_rem_next = '0;
                        div_den_next = t_reg;
                        div_kel_next = 1'b1;
                        cnt_next     = CNT_W'(DIV_W);
                        state_next   = ST_DIV;
                    end
                end
                else
                begin
                    mul_a_next = thac_pkg::ACC_W'(t_abs);
                    mul_b_next = thac_pkg::MB_W'(lmag_reg);
                    acc_next   = thac_pkg::ACC_W'(1) << 19;
                    neg_next   = t_reg[thac_pkg::T_W-1] ^ lsign_reg;
                    cnt_next   = CNT_W'(thac_pkg::MUL_STEPS);
                    state_next = ST_MUL;
                end
            end
            ST_SAT:
            begin
                if (kdiff > LIM_HI)
                begin
                    held_next = 17'(thac_pkg::TEMP_MAX);
                end
                else if (kdiff < LIM_LO)
                begin
                    held_next = 17'(thac_pkg::TEMP_MIN);
                end
                else
                begin
                    held_next = kdiff[16:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    temp_out_next  = held_reg;
                    oor_out_next   = oor_reg;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            series_reg    <= 20'd10000;
            nominal_reg   <= 20'd10000;
            held_reg      <= 17'(RST_T);
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            div_kel_reg   <= 1'b0;
            log_two_reg   <= 1'b0;
            mul_ln_reg    <= 1'b0;
            fin_reg       <= 1'b0;
            oor_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            div_kel_reg   <= div_kel_next;
            log_two_reg   <= log_two_next;
            mul_ln_reg    <= mul_ln_next;
            fin_reg       <= fin_next;
            oor_reg       <= oor_next;
            if (psel && penable && pwrite)
            begin
                unique case (paddr[2])
                    thac_pkg::REG_SERIES:  series_reg  <= pwdata[19:0];
                    thac_pkg::REG_NOMINAL: nominal_reg <= pwdata[19:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        temp_out_reg <= temp_out_next;
        oor_out_reg  <= oor_out_next;
        set_reg      <= set_next;
        k_reg        <= k_next;
        neg_reg      <= neg_next;
        lsign_reg    <= lsign_next;
        lmag_reg     <= lmag_next;
        div_num_reg  <= div_num_next;
        div_rem_reg  <= div_rem_next;
        div_den_reg  <= div_den_next;
        lv_reg       <= lv_next;
        p_reg        <= p_next;
        m_reg        <= m_next;
        sq_reg       <= sq_next;
        frac_reg     <= frac_next;
        lr_reg       <= lr_next;
        acc_reg      <= acc_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        t_reg        <= t_next;
    end

endmodule

// ----- rtl/thac_checker.sv -----
// Port-level checker for the thermistor linearizer, bound to the top level.
// Depends on thac_pkg only through the top level it watches.
module thac_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [16:0] temperature_q8_8,
    input logic               out_of_range,
    input logic               pready
);

    logic [1:0] pend_reg;
    logic seen_reg;
    logic signed [16:0] last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            seen_reg <= 1'b0;
            last_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'((in_valid && in_ready) ? 1 : 0)
                                 - 2'((out_valid && out_ready) ? 1 : 0);
            if (out_valid && out_ready)
            begin
                seen_reg <= 1'b1;
                last_reg <= temperature_q8_8;
            end
        end
    end

    a_pend: assert property (@(posedge clk) disable iff (!rst_n) pend_reg != 2'd3)
        else $error("more than two requests outstanding");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while the previous one was still in work");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range && seen_reg |-> temperature_q8_8 == last_reg)
        else $error("out-of-range result changed the held temperature");

    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(temperature_q8_8))
        else $error("stalled result dropped or changed");

    a_rdy: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind thermistor_adc_to_celsius thac_checker u_thac_checker (.*);

// ----- tb/sv/thermistor_adc_to_celsius_checker.sv -----
// Checker for the thermistor linearizer: follows the register port, the request
// and result channels, predicts each result and compares it with the block.
// Depends on thac_pkg for the band limits and register indexes.
module thermistor_adc_to_celsius_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [11:0]        adc_sample,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [16:0] temperature_q8_8,
    input  logic               out_of_range,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [16:0] temp;
        logic               oor;
    } reading_t;

    localparam logic [63:0] LN2_FIX     = 64'd186065279;
    localparam longint      OFFSET_Q8   = 69926;
    localparam logic [11:0] FULL_SCALE  = 12'hFFF;

    reading_t           expected_readings[$];
    logic [19:0]        series_ohms;
    logic [19:0]        nominal_ohms;
    logic signed [16:0] held_temp;

    function automatic longint sh_coef(input int set, input int k);
        longint tbl[16];
        tbl = '{64'sd3357042000000, 64'sd252148480000, 64'sd3374328300, -64'sd64957311,
                64'sd3354017000000, 64'sd256172440000, 64'sd2140094300, -64'sd72405219,
                64'sd3353048100000, 64'sd254202300000, 64'sd1143116300, -64'sd69383563,
                64'sd3353616600000, 64'sd253772000000, 64'sd854332710, -64'sd87912262};
        return tbl[set*4 + k];
    endfunction

    function automatic logic [63:0] log2_fix30(input logic [63:0] v);
        int          p;
        logic [63:0] m;
        logic [63:0] r;
        p = 63;
        while (p > 0 && !v[p]) p--;
        m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
        r = 64'(p) << 30;
        for (int i = 29; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic longint mul_round20(input longint a, input longint b);
        logic        neg;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] m;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m = (ma * mb + (64'd1 << 19)) >> 20;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic reading_t convert_sample(input logic [11:0] sample);
        logic [63:0] raw;
        logic [63:0] res;
        logic [63:0] r25;
        logic [63:0] mag;
        logic [63:0] lmag;
        logic [63:0] kel;
        longint      d;
        longint      l;
        longint      t;
        longint      diff;
        int          set;
        reading_t    rd;
        raw = sample;
        if (raw > FULL_SCALE - 1) raw = FULL_SCALE - 1;
        res = ((64'(series_ohms) * raw) << 16) / (FULL_SCALE - raw);
        if (res < thac_pkg::BAND0_HI && res >= thac_pkg::BAND0_LO) set = 0;
        else if (res < thac_pkg::BAND0_LO && res >= thac_pkg::BAND1_LO) set = 1;
        else if (res < thac_pkg::BAND1_LO && res >= thac_pkg::BAND2_LO) set = 2;
        else if (res < thac_pkg::BAND2_LO && res >= thac_pkg::BAND3_LO) set = 3;
        else set = -1;
        rd.oor = (set < 0);
        if (set >= 0) begin
            r25 = (nominal_ohms != 0) ? 64'(nominal_ohms) : 64'd1;
            d = longint'(log2_fix30(res)) - (longint'(16) << 30) - longint'(log2_fix30(r25));
            mag = (d < 0) ? -d : d;
            lmag = (mag * LN2_FIX + (64'd1 << 37)) >> 38;
            l = (d < 0) ? -longint'(lmag) : longint'(lmag);
            t = sh_coef(set, 3);
            t = mul_round20(t, l) + sh_coef(set, 2);
            t = mul_round20(t, l) + sh_coef(set, 1);
            t = mul_round20(t, l) + sh_coef(set, 0);
            if (t <= 0) begin
                held_temp = 17'(thac_pkg::TEMP_MAX);
            end
            else begin
                kel = ((64'd1000000000000000 << 8) + 64'(t) / 2) / 64'(t);
                diff = longint'(kel) - OFFSET_Q8;
                if (diff > thac_pkg::TEMP_MAX) diff = thac_pkg::TEMP_MAX;
                if (diff < thac_pkg::TEMP_MIN) diff = thac_pkg::TEMP_MIN;
                held_temp = diff[16:0];
            end
        end
        rd.temp = held_temp;
        return rd;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t exp_rd;
        int       errs;
        errs = 0;
        if (!rst_n) begin
            series_ohms  <= 20'd10000;
            nominal_ohms <= 20'd10000;
            held_temp    = 17'sd25600;
            expected_readings.delete();
            fail_count   <= 0;
            pending      <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == thac_pkg::REG_SERIES) series_ohms <= pwdata[19:0];
                else nominal_ohms <= pwdata[19:0];
            end
            if (in_valid && in_ready) expected_readings.push_back(convert_sample(adc_sample));
            if (out_valid && out_ready) begin
                if (expected_readings.size() == 0) begin
                    $error("result with no request outstanding");
                    errs++;
                end
                else begin
                    exp_rd = expected_readings.pop_front();
                    if (temperature_q8_8 !== exp_rd.temp) begin
                        $error("temperature_q8_8: expected %0d, got %0d",
                               exp_rd.temp, temperature_q8_8);
                        errs++;
                    end
                    if (out_of_range !== exp_rd.oor) begin
                        $error("out_of_range: expected %0d, got %0d",
                               exp_rd.oor, out_of_range);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending    <= expected_readings.size();
        end
    end

endmodule

// ----- tb/sv/thermistor_adc_to_celsius_tb.sv -----
// Top of the thermistor linearizer testbench: clock, reset, register writes,
// sample stimulus with random gaps and stalls, watchdog and verdict.
// Depends on thac_pkg, the block and thermistor_adc_to_celsius_checker.
module thermistor_adc_to_celsius_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [11:0]        adc_sample;
    logic               out_valid;
    logic               out_ready;
    logic signed [16:0] temperature_q8_8;
    logic               out_of_range;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    logic               calm;
    int                 sample_count;

    thermistor_adc_to_celsius DUT (.*);

    thermistor_adc_to_celsius_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        int run;
        out_ready = 1'b0;
        forever
        begin
            run = $urandom_range(1, 16);
            if (!calm && $urandom_range(0, 3) == 0) begin
                out_ready = 1'b0;
                repeat (run) @(negedge clk);
            end
            else begin
                out_ready = 1'b1;
                repeat (run) @(negedge clk);
            end
        end
    end

    task automatic reg_write(input logic reg_idx, input logic [19:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = (reg_idx == thac_pkg::REG_SERIES) ? 3'd0 : 3'd4;
        pwdata  = {12'd0, value};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_sample(input logic [11:0] sample);
        if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 16)) @(negedge clk);
        in_valid   = 1'b1;
        adc_sample = sample;
        while (!in_ready) @(negedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        sample_count++;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [11:0] random_sample();
        case ($urandom_range(0, 5))
            0: return 12'($urandom_range(0, 8));
            1: return 12'($urandom_range(4087, 4095));
            2: return 12'($urandom_range(40, 400));
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    initial
    begin
        logic [11:0] directed[$];
        logic [19:0] series_set[9];
        logic [19:0] nominal_set[9];
        calm         = 1'b0;
        sample_count = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        adc_sample   = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed = '{12'd0, 12'd1, 12'd2, 12'd4094, 12'd4095, 12'd2048, 12'hAAA, 12'h555,
                     12'd75, 12'd76, 12'd237, 12'd238, 12'd1080, 12'd3102, 12'd3103,
                     12'd4020, 12'd4021, 12'd300, 12'd0, 12'd3500};
        foreach (directed[i]) send_sample(directed[i]);
        drain();

        series_set  = '{20'd10000, 20'd1, 20'hFFFFF, 20'd0, 20'd4700, 20'd100000,
                        20'd10000, 20'd2200, 20'd10000};
        nominal_set = '{20'd10000, 20'd1, 20'hFFFFF, 20'd10000, 20'd0, 20'd100000,
                        20'd3000, 20'd470000, 20'd10000};
        for (int ph = 0; ph < 9; ph++) begin
            reg_write(thac_pkg::REG_SERIES, series_set[ph]);
            reg_write(thac_pkg::REG_NOMINAL, nominal_set[ph]);
            if (ph == 8) calm = 1'b1;
            for (int n = 0; n < 148; n++) send_sample(random_sample());
            drain();
        end

        repeat (20) @(negedge clk);
        $display("Ran %0d samples over nine register settings, including zero and full scale.",
                 sample_count);
        if (fail_count == 0 && pending == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule
